[hdl/lcga_pkg.sv]
// Package for the ghost-steered LRU block cache.
// Holds widths, sizes, payload structs and the controller state type.
// No dependencies.
package lcga_pkg;

   localparam int CACHE_ENTRIES = 64;
   localparam int GHOST_ENTRIES = 64;
   localparam int OBJECT_BITS   = 16;
   localparam int BLOCK_BITS    = 32;
   localparam int RANDOM_BITS   = 16;

   localparam int CACHE_IDX_BITS = $clog2(CACHE_ENTRIES);
   localparam int GHOST_IDX_BITS = $clog2(GHOST_ENTRIES);
   localparam int CACHE_CNT_BITS = $clog2(CACHE_ENTRIES + 1);
   localparam int GHOST_CNT_BITS = $clog2(GHOST_ENTRIES + 1);
   localparam int TAG_BITS       = OBJECT_BITS + BLOCK_BITS;
   localparam int COUNT_BITS     = 32;
   localparam int PROD_BITS      = COUNT_BITS + RANDOM_BITS;

   typedef struct packed {
      logic        mode;
      logic [15:0] object_id;
      logic [31:0] block_index;
      logic [15:0] random_value;
   } req_type;

   typedef struct packed {
      logic        hit;
      logic        fetch_below;
      logic        admitted;
      logic        evicted_valid;
      logic [15:0] evicted_object;
      logic [31:0] evicted_block;
      logic [31:0] demote_ghost_hits;
      logic [31:0] read_ghost_hits;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DECIDE,
      ST_UPDATE,
      ST_OUT
   } state_type;

endpackage

[hdl/lru_cache_ghost_admission.sv]
// Top level of the ghost-steered LRU block cache.
// Depends on lcga_pkg.
//
// Usage: one block access enters on the req_ channel (valid/stall); one
// result word leaves on the rsp_ channel for every access. Each store
// (cache, demote ghost, read ghost) is a memory of tag, valid bit and age
// per entry. An access sweeps all entries once to search the three stores
// and find free slots and the cache's LRU entry, then sweeps again to age
// and rewrite entries, reading one entry per cycle from each memory
// through a registered read port. N = max(CACHE_ENTRIES, GHOST_ENTRIES).
// Each sweep covers N entries; an access passes through the scan sweep,
// one decide step, the update sweep and one output step; the next access
// is taken once the block is idle again. One item is in flight at a time.
// Reset clears every valid bit and age with a pass over all N entries, during
// which no item is taken, and zeroes the ghost hit counts. A result that
// the receiver stalls is held in the output register; the block still
// takes and works the next access, and holds that access's result in its
// last cycle until the output register frees.
module lru_cache_ghost_admission (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  lcga_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output lcga_pkg::rsp_type rsp_data
);
   import lcga_pkg::*;

   localparam int N     = (CACHE_ENTRIES > GHOST_ENTRIES) ? CACHE_ENTRIES : GHOST_ENTRIES;
   localparam int IB    = $clog2(N);
   localparam int CB    = $clog2(N + 1);
   localparam int ENT_W = 1 + TAG_BITS + IB;

   // Entry layout: valid, tag, age. Stores use a common depth N; entries
   // past a store's own capacity are cleared at reset and otherwise never written.
   logic [ENT_W-1:0] cmem [N];
   logic [ENT_W-1:0] dmem [N];
   logic [ENT_W-1:0] rmem [N];
   logic [ENT_W-1:0] crd_ff, drd_ff, rrd_ff;
   logic [IB-1:0]    raddr, waddr;
   logic             cwe, dwe, rwe;
   logic [ENT_W-1:0] cwd, dwd, rwd;

   always_ff @(posedge clock) begin
      if (cwe) cmem[waddr] <= cwd;
      if (dwe) dmem[waddr] <= dwd;
      if (rwe) rmem[waddr] <= rwd;
      crd_ff <= cmem[raddr];
      drd_ff <= dmem[raddr];
      rrd_ff <= rmem[raddr];
   end

   state_type state_ff, state_in;
   req_type   req_ff;
   rsp_type   rsp_ff, rsp_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      clr_ff, clr_in;
   logic [CB-1:0] ptr_ff, ptr_in;      // sweep address
   logic      rv_ff, rv_in;            // read data valid for entry ptr-1
   logic [IB-1:0] rix_ff, rix_in;      // index of data in rd regs
   logic [31:0] dcnt_ff, dcnt_in, rcnt_ff, rcnt_in;
   logic [CACHE_CNT_BITS-1:0] ccount_ff, ccount_in;
   logic [GHOST_CNT_BITS-1:0] dcount_ff, dcount_in, rcount_ff, rcount_in;

   // Search results of the first sweep
   logic c_hit_ff, c_hit_in, d_hit_ff, d_hit_in, r_hit_ff, r_hit_in;
   logic [IB-1:0] c_age_ff, c_age_in, d_age_ff, d_age_in, r_age_ff, r_age_in;
   logic [IB-1:0] free_c_ff, free_c_in, free_d_ff, free_d_in, free_r_ff, free_r_in;
   logic fc_ok_ff, fc_ok_in, fd_ok_ff, fd_ok_in, fr_ok_ff, fr_ok_in;
   logic [TAG_BITS-1:0] lru_tag_ff, lru_tag_in;
   logic [IB-1:0] lru_ix_ff, lru_ix_in;
   // Decision
   logic adm_ff, adm_in, evict_ff, evict_in;
   logic [PROD_BITS-1:0] lhs_ff, lhs_in, rhs_ff, rhs_in;
   logic cmp_mode_ff, cmp_mode_in; // 0 fixed result, 1 use compare
   logic cmp_fix_ff, cmp_fix_in;

   logic [TAG_BITS-1:0] tag;
   assign tag = {req_ff.object_id[OBJECT_BITS-1:0], req_ff.block_index[BLOCK_BITS-1:0]};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         clr_ff       <= 1'b1;
         ptr_ff       <= '0;
         rv_ff        <= 1'b0;
         dcnt_ff      <= '0;
         rcnt_ff      <= '0;
         ccount_ff    <= '0;
         dcount_ff    <= '0;
         rcount_ff    <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         clr_ff       <= clr_in;
         ptr_ff       <= ptr_in;
         rv_ff        <= rv_in;
         dcnt_ff      <= dcnt_in;
         rcnt_ff      <= rcnt_in;
         ccount_ff    <= ccount_in;
         dcount_ff    <= dcount_in;
         rcount_ff    <= rcount_in;
      end
      req_ff <= (state_ff == ST_IDLE) ? req_data : req_ff;
      rsp_ff <= rsp_in;
      rix_ff <= rix_in;
      c_hit_ff <= c_hit_in; d_hit_ff <= d_hit_in; r_hit_ff <= r_hit_in;
      c_age_ff <= c_age_in; d_age_ff <= d_age_in; r_age_ff <= r_age_in;
      free_c_ff <= free_c_in; free_d_ff <= free_d_in; free_r_ff <= free_r_in;
      fc_ok_ff <= fc_ok_in; fd_ok_ff <= fd_ok_in; fr_ok_ff <= fr_ok_in;
      lru_tag_ff <= lru_tag_in; lru_ix_ff <= lru_ix_in;
      adm_ff <= adm_in; evict_ff <= evict_in;
      lhs_ff <= lhs_in; rhs_ff <= rhs_in;
      cmp_mode_ff <= cmp_mode_in; cmp_fix_ff <= cmp_fix_in;
   end

   assign req_stall = !(state_ff == ST_IDLE) || clr_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // Ghost-side actions for the update pass
   logic g_d_del, g_r_del, g_d_push, g_r_push;
   logic g_d_full_ev, g_r_full_ev;
   logic [IB-1:0] d_del_age, r_del_age;
   logic in_c, in_d, in_r;

   always_comb begin
      logic [IB-1:0] idx;
      logic          cv, dv, rv;
      logic [TAG_BITS-1:0] ct, dt, rt;
      logic [IB-1:0] ca, da, ra;
      logic [IB-1:0] na;
      logic          keep;
      logic [CACHE_CNT_BITS-1:0] cc_lru;
      logic          admit;

      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;
      clr_in       = clr_ff;
      ptr_in       = ptr_ff;
      rv_in        = 1'b0;
      rix_in       = ptr_ff[IB-1:0];
      dcnt_in      = dcnt_ff;
      rcnt_in      = rcnt_ff;
      ccount_in    = ccount_ff;
      dcount_in    = dcount_ff;
      rcount_in    = rcount_ff;
      c_hit_in = c_hit_ff; d_hit_in = d_hit_ff; r_hit_in = r_hit_ff;
      c_age_in = c_age_ff; d_age_in = d_age_ff; r_age_in = r_age_ff;
      free_c_in = free_c_ff; free_d_in = free_d_ff; free_r_in = free_r_ff;
      fc_ok_in = fc_ok_ff; fd_ok_in = fd_ok_ff; fr_ok_in = fr_ok_ff;
      lru_tag_in = lru_tag_ff; lru_ix_in = lru_ix_ff;
      adm_in = adm_ff; evict_in = evict_ff;
      lhs_in = lhs_ff; rhs_in = rhs_ff;
      cmp_mode_in = cmp_mode_ff; cmp_fix_in = cmp_fix_ff;
      raddr = ptr_ff[IB-1:0];
      waddr = rix_ff;
      cwe = 1'b0; dwe = 1'b0; rwe = 1'b0;
      cwd = '0; dwd = '0; rwd = '0;
      idx = rix_ff;
      in_c = ({1'b0, idx} < (IB+1)'(CACHE_ENTRIES));
      in_d = ({1'b0, idx} < (IB+1)'(GHOST_ENTRIES));
      in_r = in_d;
      {cv, ct, ca} = crd_ff;
      {dv, dt, da} = drd_ff;
      {rv, rt, ra} = rrd_ff;
      na = '0; keep = 1'b0;
      cc_lru = ccount_ff - 1'b1;
      admit = 1'b0;

      // Ghost actions derived from search results
      g_d_del   = d_hit_ff;                   // read drop or demote re-put
      g_r_del   = r_hit_ff && !req_ff.mode;   // a demote leaves the read ghost alone
      g_d_push  = req_ff.mode;
      g_r_push  = !req_ff.mode;
      d_del_age = d_age_ff;
      r_del_age = r_age_ff;
      g_d_full_ev = g_d_push && !d_hit_ff &&
                    (dcount_ff == GHOST_CNT_BITS'(GHOST_ENTRIES));
      g_r_full_ev = g_r_push && !r_hit_ff &&
                    (rcount_ff == GHOST_CNT_BITS'(GHOST_ENTRIES));

      case (state_ff)
         ST_IDLE: begin
            if (clr_ff) begin
               // clearing pass after reset
               cwe = 1'b1; dwe = 1'b1; rwe = 1'b1;
               waddr = ptr_ff[IB-1:0];
               ptr_in = ptr_ff + 1'b1;
               if (ptr_ff == CB'(N - 1)) begin
                  clr_in = 1'b0;
                  ptr_in = '0;
               end
            end else if (req_valid) begin
               state_in = ST_SCAN;
               ptr_in = '0;
               c_hit_in = 1'b0; d_hit_in = 1'b0; r_hit_in = 1'b0;
               fc_ok_in = 1'b0; fd_ok_in = 1'b0; fr_ok_in = 1'b0;
               lru_tag_in = '0; lru_ix_in = '0;
            end
         end
         ST_SCAN: begin
            if (ptr_ff != CB'(N)) ptr_in = ptr_ff + 1'b1;
            rv_in = (ptr_ff != CB'(N));
            if (rv_ff) begin
               if (in_c) begin
                  if (cv && ct == tag) begin c_hit_in = 1'b1; c_age_in = ca; end
                  if (!cv && !fc_ok_ff) begin fc_ok_in = 1'b1; free_c_in = idx; end
                  if (cv && {1'b0, ca} == cc_lru) begin
                     lru_tag_in = ct; lru_ix_in = idx;
                  end
               end
               if (in_d) begin
                  if (dv && dt == tag) begin d_hit_in = 1'b1; d_age_in = da; end
                  if (!dv && !fd_ok_ff) begin fd_ok_in = 1'b1; free_d_in = idx; end
                  if (rv && rt == tag) begin r_hit_in = 1'b1; r_age_in = ra; end
                  if (!rv && !fr_ok_ff) begin fr_ok_in = 1'b1; free_r_in = idx; end
               end
            end
            if (!rv_ff && ptr_ff == CB'(N)) begin
               state_in = ST_DECIDE;
               // ghost counts rise on a read hit
               if (!req_ff.mode) begin
                  if (d_hit_ff && dcnt_ff != '1) dcnt_in = dcnt_ff + 1'b1;
                  if (r_hit_ff && rcnt_ff != '1) rcnt_in = rcnt_ff + 1'b1;
               end
            end
         end
         ST_DECIDE: begin
            // set up the compare of v * x <= y * M with registered products
            state_in = ST_UPDATE;
            ptr_in = '0;
            cmp_mode_in = 1'b0;
            cmp_fix_in = 1'b0;
            if (dcnt_ff < rcnt_ff) begin
               if (!req_ff.mode) cmp_fix_in = 1'b1;
               else begin
                  cmp_mode_in = 1'b1;
                  lhs_in = PROD_BITS'(req_ff.random_value[RANDOM_BITS-1:0]) * PROD_BITS'(rcnt_ff);
                  rhs_in = PROD_BITS'(dcnt_ff) * PROD_BITS'({RANDOM_BITS{1'b1}});
               end
            end else if (req_ff.mode) cmp_fix_in = 1'b1;
            else if (dcnt_ff == '0) cmp_fix_in = 1'b0;
            else begin
               cmp_mode_in = 1'b1;
               lhs_in = PROD_BITS'(req_ff.random_value[RANDOM_BITS-1:0]) * PROD_BITS'(dcnt_ff);
               rhs_in = PROD_BITS'(rcnt_ff) * PROD_BITS'({RANDOM_BITS{1'b1}});
            end
            adm_in = 1'b0;
            evict_in = 1'b0;
         end
         ST_UPDATE: begin
            if (ptr_ff == '0) begin
               admit = cmp_mode_ff ? (lhs_ff <= rhs_ff) : cmp_fix_ff;
               if (!c_hit_ff) begin
                  if (ccount_ff != CACHE_CNT_BITS'(CACHE_ENTRIES)) adm_in = 1'b1;
                  else begin
                     adm_in = admit;
                     evict_in = admit;
                  end
               end
            end
            if (ptr_ff != CB'(N)) ptr_in = ptr_ff + 1'b1;
            rv_in = (ptr_ff != CB'(N));
            if (rv_ff) begin
               // cache entry rewrite
               if (in_c) begin
                  na = ca; keep = cv;
                  if (c_hit_ff) begin
                     if (cv && ca < c_age_ff) na = ca + 1'b1;
                     if (cv && ct == tag) na = '0;
                  end else if (adm_ff) begin
                     if (evict_ff && idx == lru_ix_ff) begin
                        na = '0; keep = 1'b1; ct = tag;
                     end else if (!evict_ff && fc_ok_ff && idx == free_c_ff) begin
                        na = '0; keep = 1'b1; ct = tag;
                     end else if (cv) na = ca + 1'b1;
                  end
                  cwe = 1'b1; cwd = {keep, ct, na};
               end
               if (in_d) begin
                  // demote ghost
                  na = da; keep = dv;
                  if (g_d_del) begin
                     if (dv && da > d_del_age) na = da - 1'b1;
                     if (dv && dt == tag) keep = 1'b0;
                  end
                  if (g_d_push) begin
                     if (g_d_full_ev && dv && {1'b0, da} == GHOST_CNT_BITS'(GHOST_ENTRIES - 1))
                        keep = 1'b0;
                     else if (keep) na = na + 1'b1;
                     if (d_hit_ff ? (dv && dt == tag) :
                         (g_d_full_ev ? (dv && {1'b0, da} ==
                                        GHOST_CNT_BITS'(GHOST_ENTRIES - 1))
                                      : (fd_ok_ff && idx == free_d_ff))) begin
                        keep = 1'b1; na = '0; dt = tag;
                     end
                  end
                  dwe = 1'b1; dwd = {keep, dt, na};
                  // read ghost
                  na = ra; keep = rv;
                  if (g_r_del) begin
                     if (rv && ra > r_del_age) na = ra - 1'b1;
                     if (rv && rt == tag) keep = 1'b0;
                  end
                  if (g_r_push) begin
                     if (g_r_full_ev && rv && {1'b0, ra} == GHOST_CNT_BITS'(GHOST_ENTRIES - 1))
                        keep = 1'b0;
                     else if (keep) na = na + 1'b1;
                     if (r_hit_ff ? (rv && rt == tag) :
                         (g_r_full_ev ? (rv && {1'b0, ra} ==
                                        GHOST_CNT_BITS'(GHOST_ENTRIES - 1))
                                      : (fr_ok_ff && idx == free_r_ff))) begin
                        keep = 1'b1; na = '0; rt = tag;
                     end
                  end
                  rwe = 1'b1; rwd = {keep, rt, na};
               end
            end
            if (!rv_ff && ptr_ff == CB'(N)) state_in = ST_OUT;
         end
         ST_OUT: begin
            // hold here while the previous word still waits in the output register
            if (!rsp_valid_ff || !rsp_stall) begin
               // counts: cache grows on a free insert; ghosts net of drops and puts
               if (!c_hit_ff && adm_ff && !evict_ff) ccount_in = ccount_ff + 1'b1;
               if (g_d_push && !d_hit_ff && !g_d_full_ev) dcount_in = dcount_ff + 1'b1;
               if (!req_ff.mode && d_hit_ff) dcount_in = dcount_ff - 1'b1;
               if (g_r_push && !r_hit_ff && !g_r_full_ev) rcount_in = rcount_ff + 1'b1;
               rsp_in.hit               = c_hit_ff;
               rsp_in.fetch_below       = !c_hit_ff && !req_ff.mode;
               rsp_in.admitted          = !c_hit_ff && adm_ff;
               rsp_in.evicted_valid     = !c_hit_ff && evict_ff;
               rsp_in.evicted_object    = (!c_hit_ff && evict_ff) ?
                                          16'(lru_tag_ff[TAG_BITS-1:BLOCK_BITS]) : '0;
               rsp_in.evicted_block     = (!c_hit_ff && evict_ff) ?
                                          32'(lru_tag_ff[BLOCK_BITS-1:0]) : '0;
               rsp_in.demote_ghost_hits = dcnt_ff;
               rsp_in.read_ghost_hits   = rcnt_ff;
               rsp_valid_in = 1'b1;
               ptr_in   = '0;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule
